FILE: hw/rtl/multicore_lock_request_counter_top_assert.svh
// Assertion macros for the lock request counter (clocked on clk_i, reset rst_ni).
`ifndef MULTICORE_LOCK_REQUEST_COUNTER_TOP_ASSERT_SVH
`define MULTICORE_LOCK_REQUEST_COUNTER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MLRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mlrc assertion failed");
`define MLRC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("mlrc forbidden condition seen");
`else
`define MLRC_ASSERT(lbl, prop)
`define MLRC_ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: hw/rtl/mlrc_pkg.sv
// Package: op and status codes, sequencer states for the lock request counter.
package mlrc_pkg;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned CNT_W = 16;

  localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_PARAM    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_INIT = 2'd2;
  localparam logic [ST_W-1:0] ST_ZERO     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_LAST,
    S_UPDATE,
    S_RESULT
  } state_e;

endpackage

FILE: hw/rtl/mlrc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module mlrc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/multicore_lock_request_counter_top.sv
// Lock request counter: per-resource ready flags and per-CPU request counts.
//
// Request channel (in_valid_i/in_ready_o): op_i, res_id_i, cpu_id_i. One result per
// request on the result channel (out_valid_o/out_ready_i): status_o, self_count_o,
// others_count_o. Only one request is in flight; in_ready_o is high while idle.
// Sequencer path from request accept to result valid:
//   error, or init of a ready resource:  straight to S_RESULT
//   init of a fresh resource:            S_CLEAR (one count cleared a cycle), then S_RESULT
//   acquire / release:                   S_READ per count, S_LAST, S_UPDATE, S_RESULT
// The acquire/release path is set by the count RAM's single read port: every CPU's
// count of the resource is read and summed by one adder, one count per cycle, then a
// read-modify-write of the own count. A new request is taken only after the result
// has been handed to the output register.
// A finished result sits in the output register; the block goes idle and takes the
// next request while that result waits, but holds the next result until the output
// register is free. Reset clears all ready flags and the handshake state; the count
// RAM is not cleared, init writes a resource's counts before they are ever read.
module multicore_lock_request_counter_top #(
  parameter int unsigned RES_COUNT = 16,
  parameter int unsigned CPU_COUNT = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  res_id_i,
  input  logic [7:0]  cpu_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] self_count_o,
  output logic [15:0] others_count_o
);

  localparam int unsigned DEPTH = RES_COUNT * CPU_COUNT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(CPU_COUNT);
  localparam int unsigned RW    = (RES_COUNT > 1) ? $clog2(RES_COUNT) : 1;
  localparam int unsigned CNTW  = mlrc_pkg::CNT_W;
  localparam int unsigned STW   = mlrc_pkg::ST_W;

  mlrc_pkg::state_e state_q, state_d;

  logic [RES_COUNT-1:0] ready_q, ready_d;
  logic                 out_valid_q, out_valid_d;
  logic                 pend_q, pend_d;

  logic [RW-1:0]   res_idx_q, res_idx_d;
  logic [AW-1:0]   base_q, base_d;
  logic [CW-1:0]   cpu_q, cpu_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   rd_cnt_q, rd_cnt_d;
  logic            is_acq_q, is_acq_d;
  logic [CNTW-1:0] acc_q, acc_d;
  logic [CNTW-1:0] own_q, own_d;
  logic [STW-1:0]  rs_status_q, rs_status_d;
  logic [CNTW-1:0] rs_self_q, rs_self_d;
  logic [CNTW-1:0] rs_others_q, rs_others_d;
  logic [STW-1:0]  out_status_q, out_status_d;
  logic [CNTW-1:0] out_self_q, out_self_d;
  logic [CNTW-1:0] out_others_q, out_others_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [CNTW-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [CNTW-1:0] ram_rdata;

  logic          res_ok, cpu_ok, rdy_hit;
  logic [RW-1:0] in_res_idx;

  assign res_ok     = {1'b0, res_id_i} < 9'(RES_COUNT);
  assign cpu_ok     = {1'b0, cpu_id_i} < 9'(CPU_COUNT);
  assign in_res_idx = res_id_i[RW-1:0];
  assign rdy_hit    = res_ok && ready_q[in_res_idx];

  mlrc_ram #(
    .WIDTH(CNTW),
    .DEPTH(DEPTH)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    ready_d      = ready_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    pend_d       = 1'b0;
    res_idx_d    = res_idx_q;
    base_d       = base_q;
    cpu_d        = cpu_q;
    cnt_d        = cnt_q;
    rd_cnt_d     = rd_cnt_q;
    is_acq_d     = is_acq_q;
    acc_d        = acc_q;
    own_d        = own_q;
    rs_status_d  = rs_status_q;
    rs_self_d    = rs_self_q;
    rs_others_d  = rs_others_q;
    out_status_d = out_status_q;
    out_self_d   = out_self_q;
    out_others_d = out_others_q;
    ram_we       = 1'b0;
    ram_waddr    = base_q + AW'(cnt_q);
    ram_wdata    = '0;
    ram_raddr    = base_q + AW'(cnt_q);
    in_ready_o   = 1'b0;

    // read data of the previous cycle's read: add into the running sum
    if (pend_q) begin
      acc_d = acc_q + ram_rdata;
      if (rd_cnt_q == cpu_q) begin
        own_d = ram_rdata;
      end
    end

    unique case (state_q)
      mlrc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_idx_d   = in_res_idx;
          base_d      = AW'(AW'(in_res_idx) * AW'(CPU_COUNT));
          cpu_d       = cpu_id_i[CW-1:0];
          cnt_d       = '0;
          acc_d       = '0;
          is_acq_d    = (op_i == mlrc_pkg::OP_ACQUIRE);
          rs_status_d = mlrc_pkg::ST_OK;
          rs_self_d   = '0;
          rs_others_d = '0;
          state_d     = mlrc_pkg::S_RESULT;
          if (!res_ok || (op_i != mlrc_pkg::OP_INIT && op_i != mlrc_pkg::OP_ACQUIRE &&
                          op_i != mlrc_pkg::OP_RELEASE)) begin
            rs_status_d = mlrc_pkg::ST_PARAM;
          end else if (op_i == mlrc_pkg::OP_INIT) begin
            if (!rdy_hit) begin
              state_d = mlrc_pkg::S_CLEAR;
            end
          end else if (!rdy_hit) begin
            rs_status_d = mlrc_pkg::ST_NOT_INIT;
          end else if (!cpu_ok) begin
            rs_status_d = mlrc_pkg::ST_PARAM;
          end else begin
            state_d = mlrc_pkg::S_READ;
          end
        end
      end
      mlrc_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CW'(CPU_COUNT - 1)) begin
          ready_d[res_idx_q] = 1'b1;
          state_d            = mlrc_pkg::S_RESULT;
        end
      end
      mlrc_pkg::S_READ: begin
        pend_d   = 1'b1;
        rd_cnt_d = cnt_q;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CW'(CPU_COUNT - 1)) begin
          state_d = mlrc_pkg::S_LAST;
        end
      end
      mlrc_pkg::S_LAST: begin
        state_d = mlrc_pkg::S_UPDATE;
      end
      mlrc_pkg::S_UPDATE: begin
        // sum less own is the others' total both before and after the update
        ram_waddr   = base_q + AW'(cpu_q);
        rs_others_d = acc_q - own_q;
        state_d     = mlrc_pkg::S_RESULT;
        if (is_acq_q) begin
          ram_we    = 1'b1;
          ram_wdata = own_q + 1'b1;
          rs_self_d = own_q;
        end else if (own_q == '0) begin
          rs_status_d = mlrc_pkg::ST_ZERO;
          rs_others_d = '0;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = own_q - 1'b1;
          rs_self_d = own_q - 1'b1;
        end
      end
      mlrc_pkg::S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = rs_status_q;
          out_self_d   = rs_self_q;
          out_others_d = rs_others_q;
          state_d      = mlrc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mlrc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlrc_pkg::S_IDLE;
      ready_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_idx_q    <= res_idx_d;
    base_q       <= base_d;
    cpu_q        <= cpu_d;
    cnt_q        <= cnt_d;
    rd_cnt_q     <= rd_cnt_d;
    is_acq_q     <= is_acq_d;
    acc_q        <= acc_d;
    own_q        <= own_d;
    rs_status_q  <= rs_status_d;
    rs_self_q    <= rs_self_d;
    rs_others_q  <= rs_others_d;
    out_status_q <= out_status_d;
    out_self_q   <= out_self_d;
    out_others_q <= out_others_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign self_count_o   = out_self_q;
  assign others_count_o = out_others_q;

`include "multicore_lock_request_counter_top_assert.svh"

  `MLRC_ASSERT(a_err_zero_counts, (out_valid_o && status_o != mlrc_pkg::ST_OK) |-> (self_count_o == '0 && others_count_o == '0))
  `MLRC_ASSERT_NEVER(a_no_write_idle, ram_we && state_q == mlrc_pkg::S_IDLE)
  `MLRC_ASSERT(a_ready_sticky, 1'b1 |=> ((ready_q & $past(ready_q)) == $past(ready_q)))
  `MLRC_ASSERT(a_accept_leaves_idle, (in_valid_i && in_ready_o) |=> (state_q != mlrc_pkg::S_IDLE))
  `MLRC_ASSERT(a_result_from_seq, $rose(out_valid_o) |-> $past(state_q == mlrc_pkg::S_RESULT))

endmodule
